### design/hkv_pkg.sv
// Package for the hash key-value table: sizes, codes, item and metadata types.
// Depends on nothing; used by hash_key_value_table and its checker.
package hkv_pkg;

   localparam int NUM_BUCKETS = 256;
   localparam int WAYS        = 4;
   localparam int ENTRIES     = NUM_BUCKETS * WAYS;

   localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_W = WAY_W;
   localparam int ENT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int KEY_W  = 32;
   localparam int CNT_W  = 9;
   localparam int BIT_W  = $clog2(KEY_W);
   localparam int ADDR_W = 3;

   localparam logic [CNT_W-1:0] BUCKET_COUNT_RESET = CNT_W'(256);

   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_GET    = 2'd1,
      FUNC_RGET   = 2'd2,
      FUNC_REMOVE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   // Register index, taken from paddr[2]
   typedef enum logic {
      REG_BUCKET_COUNT = 1'b0
   } reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_META,
      ST_SCAN,
      ST_FINISH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]       func;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] result_word;
      logic [1:0]       status;
   } rsp_type;

   typedef struct packed {
      logic [WAYS-1:0]              vld;
      logic [WAYS-1:0][RANK_W-1:0]  rank;
   } meta_row_type;

endpackage

### design/hash_key_value_table.sv
// Hash key-value table with bounded chains: top level, storage and sequencer.
// Depends on hkv_pkg for types, sizes and codes.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | req_data (func, key, value)
//   rsp     | out       | rsp_valid / rsp_stall  | rsp_data (result_word, status)
//   csr     | in/out    | APB, pready always 1   | bucket_count at byte address 0
//
// For insert, get and remove, the bucket index comes from a one-bit-per-cycle
// remainder over the 32-bit key, then the ways of the bucket are read one per
// cycle from the entry memory, which has one write port and one registered read port.
// Reverse lookup scans the used buckets in order from bucket 0 until a match is found.
// Reset is synchronous; it clears the per-bucket row-valid flags, no clearing pass.
// One item is in work at a time; a new item is taken while a result waits on rsp_stall.
module hash_key_value_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  hkv_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hkv_pkg::rsp_type              rsp_data,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [hkv_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready
);
   import hkv_pkg::*;

   // Storage
   logic [2*KEY_W-1:0] kv_mem   [ENTRIES];
   meta_row_type       meta_mem [NUM_BUCKETS];
   logic [NUM_BUCKETS-1:0] row_vld_ff;

   state_type state_ff, state_in;

   logic [1:0]        func_ff, func_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  value_ff, value_in;
   logic [KEY_W-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [BIT_W-1:0]  cnt_ff, cnt_in;
   logic [BKT_W-1:0]  bucket_ff, bucket_in;
   logic [WAY_W-1:0]  way_ff, way_in;
   logic              found_ff, found_in;
   logic [RANK_W-1:0] best_rank_ff, best_rank_in;
   logic [WAY_W-1:0]  best_way_ff, best_way_in;
   logic [KEY_W-1:0]  best_word_ff, best_word_in;
   logic [KEY_W-1:0]  word_ff, word_in;
   logic [1:0]        status_ff, status_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic [CNT_W-1:0]  bucket_count_ff;

   meta_row_type      meta_rd_ff;
   logic              row_hit_ff;
   logic [2*KEY_W-1:0] kv_rd_ff;

   logic              req_take;
   logic              rsp_free;
   logic [CNT_W-1:0]  used;
   logic [CNT_W:0]    trial;
   logic [CNT_W-1:0]  rem_next;
   meta_row_type      meta_cur;
   meta_row_type      meta_new;
   logic              meta_we;
   logic              kv_we;
   logic [ENT_W-1:0]  kv_raddr;
   logic [ENT_W-1:0]  kv_waddr;
   logic [WAY_W-1:0]  rd_way;
   logic [WAY_W-1:0]  free_way;
   logic              has_free;
   logic [KEY_W-1:0]  cand_key;
   logic [KEY_W-1:0]  cand_val;
   logic              way_match;
   logic              last_way;
   logic              last_bucket;

   assign req_take = req_valid && !req_stall;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // Clamp bucket count to 1..NUM_BUCKETS
   always_comb begin
      used = bucket_count_ff;
      if (bucket_count_ff == '0) begin
         used = CNT_W'(1);
      end
      if (32'(bucket_count_ff) > NUM_BUCKETS) begin
         used = CNT_W'(NUM_BUCKETS);
      end
   end

   // Restoring remainder step, one key bit per cycle
   assign trial    = {rem_ff, shift_ff[KEY_W-1]};
   assign rem_next = (trial >= {1'b0, used}) ? CNT_W'(trial - {1'b0, used})
                                             : trial[CNT_W-1:0];

   // Metadata of the current row; a row never written reads as empty
   assign meta_cur = row_hit_ff ? meta_rd_ff : '0;

   assign cand_key = kv_rd_ff[2*KEY_W-1:KEY_W];
   assign cand_val = kv_rd_ff[KEY_W-1:0];
   assign way_match = meta_cur.vld[way_ff] &&
                      ((func_ff == FUNC_RGET) ? (cand_val == value_ff)
                                              : (cand_key == key_ff));
   assign last_way    = (32'(way_ff) == WAYS - 1);
   assign last_bucket = ({1'b0, bucket_ff} == CNT_W'(used - CNT_W'(1)));

   // Lowest free way of the bucket
   always_comb begin
      free_way = '0;
      has_free = 1'b0;
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (!meta_cur.vld[i]) begin
            free_way = WAY_W'(i);
            has_free = 1'b1;
         end
      end
   end

   // Next way to read during the scan
   always_comb begin
      rd_way = '0;
      if (state_ff == ST_SCAN && !last_way) begin
         rd_way = WAY_W'(way_ff + WAY_W'(1));
      end
   end

   assign kv_raddr = ENT_W'(ENT_W'(bucket_ff) * ENT_W'(WAYS) + ENT_W'(rd_way));
   assign kv_waddr = ENT_W'(ENT_W'(bucket_ff) * ENT_W'(WAYS) + ENT_W'(free_way));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = (req_data.func == FUNC_RGET) ? ST_META : ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == BIT_W'(KEY_W - 1)) begin
               state_in = ST_META;
            end
         end
         ST_META: state_in = ST_SCAN;
         ST_SCAN: begin
            if (last_way) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (func_ff == FUNC_RGET && !found_ff && !last_bucket) begin
               state_in = ST_META;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory write controls
   always_comb begin
      func_in      = func_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      bucket_in    = bucket_ff;
      way_in       = way_ff;
      found_in     = found_ff;
      best_rank_in = best_rank_ff;
      best_way_in  = best_way_ff;
      best_word_in = best_word_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      meta_we      = 1'b0;
      kv_we        = 1'b0;
      meta_new     = meta_cur;
      req_stall    = (state_ff != ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_in   = req_data.func;
               key_in    = req_data.key;
               value_in  = req_data.value;
               shift_in  = req_data.key;
               rem_in    = '0;
               cnt_in    = '0;
               bucket_in = '0;
            end
         end
         ST_DIV: begin
            rem_in   = rem_next;
            shift_in = {shift_ff[KEY_W-2:0], 1'b0};
            cnt_in   = BIT_W'(cnt_ff + BIT_W'(1));
            if (cnt_ff == BIT_W'(KEY_W - 1)) begin
               bucket_in = BKT_W'(rem_next);
            end
         end
         ST_META: begin
            way_in   = '0;
            found_in = 1'b0;
         end
         ST_SCAN: begin
            // Keep the newest matching way
            if (way_match && (!found_ff || meta_cur.rank[way_ff] < best_rank_ff)) begin
               found_in     = 1'b1;
               best_rank_in = meta_cur.rank[way_ff];
               best_way_in  = way_ff;
               best_word_in = (func_ff == FUNC_RGET) ? cand_key : cand_val;
            end
            way_in = rd_way;
         end
         ST_FINISH: begin
            word_in   = '0;
            status_in = STATUS_OK;
            case (func_ff)
               FUNC_INSERT: begin
                  if (has_free) begin
                     kv_we   = 1'b1;
                     meta_we = 1'b1;
                     for (int i = 0; i < WAYS; i++) begin
                        if (meta_cur.vld[i]) begin
                           meta_new.rank[i] = RANK_W'(meta_cur.rank[i] + RANK_W'(1));
                        end
                     end
                     meta_new.vld[free_way]  = 1'b1;
                     meta_new.rank[free_way] = '0;
                  end else begin
                     status_in = STATUS_FULL;
                  end
               end
               FUNC_GET, FUNC_RGET: begin
                  if (found_ff) begin
                     word_in = best_word_ff;
                  end else begin
                     status_in = STATUS_MISS;
                  end
                  if (func_ff == FUNC_RGET && !found_ff && !last_bucket) begin
                     bucket_in = BKT_W'(bucket_ff + BKT_W'(1));
                  end
               end
               FUNC_REMOVE: begin
                  if (found_ff) begin
                     meta_we = 1'b1;
                     for (int i = 0; i < WAYS; i++) begin
                        if (meta_cur.vld[i] && meta_cur.rank[i] > best_rank_ff) begin
                           meta_new.rank[i] = RANK_W'(meta_cur.rank[i] - RANK_W'(1));
                        end
                     end
                     meta_new.vld[best_way_ff]  = 1'b0;
                     meta_new.rank[best_way_ff] = '0;
                  end else begin
                     status_in = STATUS_MISS;
                  end
               end
               default: status_in = STATUS_MISS;
            endcase
         end
         ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_word = word_ff;
               rsp_data_in.status      = status_ff;
            end
         end
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_vld_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (meta_we) begin
            row_vld_ff[bucket_ff] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      shift_ff     <= shift_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      bucket_ff    <= bucket_in;
      way_ff       <= way_in;
      found_ff     <= found_in;
      best_rank_ff <= best_rank_in;
      best_way_ff  <= best_way_in;
      best_word_ff <= best_word_in;
      word_ff      <= word_in;
      status_ff    <= status_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (kv_we) begin
         kv_mem[kv_waddr] <= {key_ff, value_ff};
      end
      kv_rd_ff <= kv_mem[kv_raddr];
   end

   // Bucket metadata memory: read-modify-write of one row
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[bucket_ff] <= meta_new;
      end
      meta_rd_ff <= meta_mem[bucket_ff];
      row_hit_ff <= row_vld_ff[bucket_ff];
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_BUCKET_COUNT) begin
         bucket_count_ff <= csr_pwdata[CNT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_BUCKET_COUNT) ? 32'(bucket_count_ff) : '0;
   assign csr_pready = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

### design/hkv_checker.sv
// Port-level checks for the hash key-value table, bound to its top level.
// Depends on hkv_pkg for the item types and status codes.
module hkv_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input hkv_pkg::rsp_type rsp_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             csr_pready
);
   import hkv_pkg::*;

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // An accepted item blocks the next one until its result is made
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken while one is in work");

   // Only defined status codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_MISS ||
                     rsp_data.status == STATUS_FULL))
      else $error("undefined status code");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("pready dropped");

endmodule

bind hash_key_value_table hkv_checker u_hkv_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_data   (rsp_data),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .csr_pready (csr_pready)
);
